FILE: rtl/mrrs_pkg.sv
// shared types, constants and the byte-wise crc-16 step for the modbus rtu request scanner
// no dependencies
package mrrs_pkg;

	localparam int BUFFER_DEPTH = 512;
	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int LEN_W = 9;
	localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FC_WRITE_COILS = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS = 8'd16;

	localparam int MIN_TAIL = 4;
	localparam int MB_TAIL = 7;
	localparam int BASE_LEN = 8;
	localparam int MB_LEN = 9;
	localparam int FLD_BYTES = 6;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_buffer;
	} rx_t;

	typedef struct packed {
		logic        found;
		logic [8:0]  frame_length;
		logic [8:0]  frame_start;
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
		logic [15:0] register_address;
		logic [15:0] count_or_value;
		logic [7:0]  data_byte_count;
		logic        overflow;
	} res_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int n = 0; n < 8; n++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/modbus_rtu_request_scanner.sv
// modbus rtu request scanner: byte buffer, offset scan sequencer and shared crc-16 byte unit
// depends on mrrs_pkg
//
// usage:
//   rx channel (rx_valid/rx_ready/rx) takes one byte per request; a byte with
//   end_of_buffer set closes the buffer and starts the scan. bytes past
//   BUFFER_DEPTH are dropped and reported through overflow.
//   res channel (res_valid/res_ready/res) gives one result per closed buffer:
//   the first offset that holds a crc-valid request frame, or found = 0.
// operation:
//   the buffer fills one byte per cycle while rx_ready is high. the scan visits
//   offsets in order through one buffer read port and one crc byte unit; each
//   offset sizes its frame from the function code and, for multi-write codes,
//   the byte count, checks the crc over all but the last two frame bytes when
//   the frame fits, and on a hit fetches the six field bytes. rx_ready is low during the scan.
// reset:
//   arst_n clears the fill count, overflow flag, sequencer and result valid.
//   buffer contents are not cleared; only bytes written since the last scan
//   are read.
// stall:
//   a finished result waits in the output register; the next buffer can be
//   filled meanwhile, and its scan holds in the last step until res is free.
module modbus_rtu_request_scanner
	import mrrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rx_valid,
	output logic rx_ready,
	input  rx_t  rx,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_TRY,
		S_FC,
		S_BC,
		S_CHK,
		S_CRC,
		S_LO,
		S_HI,
		S_FLD,
		S_RES
	} state_t;

	state_t             state_q;
	logic [7:0]         mem_q [BUFFER_DEPTH];
	logic [7:0]         rdata_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic               rx_take;
	logic [CNT_W-1:0]   fill_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   i_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic [LEN_W-1:0]   need_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [7:0]         fc_q;
	logic [7:0]         bc_q;
	logic [15:0]        crc_q;
	logic               match_lo_q;
	logic               found_q;
	logic [8*FLD_BYTES-1:0] fld_q;
	logic [2:0]         k_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [SUM_W-1:0]   len_ext;
	logic [SUM_W-1:0]   i_ext;
	logic               multi_write;

	assign rx_ready = (state_q == S_IDLE);
	assign rx_take = rx_valid && rx_ready;
	assign wr_en = rx_take && (fill_q < CNT_W'(BUFFER_DEPTH));
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign len_ext = SUM_W'(fill_q);
	assign i_ext = SUM_W'(i_q);
	assign multi_write = (rdata_q == FC_WRITE_COILS) || (rdata_q == FC_WRITE_REGS);

	always_comb begin
		unique case (state_q)
			S_TRY:                 rd_addr = ADDR_W'(i_q + CNT_W'(1));
			S_FC:                  rd_addr = ADDR_W'(i_q + CNT_W'(MB_TAIL - 1));
			S_CHK, S_HI:           rd_addr = ADDR_W'(i_q);
			S_CRC, S_LO, S_FLD:    rd_addr = ptr_q + ADDR_W'(1);
			default:               rd_addr = '0;
		endcase
	end

	// buffer memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[fill_q[ADDR_W-1:0]] <= rx.rx_byte;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			ptr_q <= '0;
			need_q <= '0;
			cnt_q <= '0;
			fc_q <= '0;
			bc_q <= '0;
			crc_q <= CRC_INIT;
			match_lo_q <= 1'b0;
			found_q <= 1'b0;
			fld_q <= '0;
			k_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (res_valid_q && res_ready && (state_q != S_RES)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rx_take) begin
						if (fill_q < CNT_W'(BUFFER_DEPTH)) begin
							fill_q <= fill_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (rx.end_of_buffer) begin
							i_q <= '0;
							found_q <= 1'b0;
							state_q <= S_TRY;
						end
					end
				end
				S_TRY: begin
					if (i_ext + SUM_W'(MIN_TAIL) > SUM_W'(fill_q)) begin
						found_q <= 1'b0;
						state_q <= S_RES;
					end else begin
						state_q <= S_FC;
					end
				end
				S_FC: begin
					fc_q <= rdata_q;
					if (multi_write) begin
						if (i_ext + SUM_W'(MB_TAIL) > len_ext) begin
							i_q <= i_q + CNT_W'(1);
							state_q <= S_TRY;
						end else begin
							state_q <= S_BC;
						end
					end else begin
						bc_q <= '0;
						need_q <= LEN_W'(BASE_LEN);
						state_q <= S_CHK;
					end
				end
				S_BC: begin
					bc_q <= rdata_q;
					need_q <= LEN_W'(MB_LEN) + LEN_W'(rdata_q);
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (i_ext + SUM_W'(need_q) > len_ext) begin
						i_q <= i_q + CNT_W'(1);
						state_q <= S_TRY;
					end else begin
						ptr_q <= ADDR_W'(i_q);
						cnt_q <= need_q - LEN_W'(2);
						crc_q <= CRC_INIT;
						state_q <= S_CRC;
					end
				end
				S_CRC: begin
					crc_q <= crc16_byte(crc_q, rdata_q);
					cnt_q <= cnt_q - LEN_W'(1);
					ptr_q <= ptr_q + ADDR_W'(1);
					if (cnt_q == LEN_W'(1)) begin
						state_q <= S_LO;
					end
				end
				S_LO: begin
					match_lo_q <= (rdata_q == crc_q[7:0]);
					ptr_q <= ptr_q + ADDR_W'(1);
					state_q <= S_HI;
				end
				S_HI: begin
					if (match_lo_q && (rdata_q == crc_q[15:8])) begin
						found_q <= 1'b1;
						ptr_q <= ADDR_W'(i_q);
						k_q <= '0;
						state_q <= S_FLD;
					end else begin
						i_q <= i_q + CNT_W'(1);
						state_q <= S_TRY;
					end
				end
				S_FLD: begin
					fld_q <= {fld_q[8*FLD_BYTES-9:0], rdata_q};
					ptr_q <= ptr_q + ADDR_W'(1);
					k_q <= k_q + 3'd1;
					if (k_q == 3'(FLD_BYTES - 1)) begin
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						res_q.found <= found_q;
						res_q.overflow <= ovf_q;
						if (found_q) begin
							res_q.frame_length <= need_q;
							res_q.frame_start <= 9'(i_q);
							res_q.slave_address <= fld_q[47:40];
							res_q.function_code <= fc_q;
							res_q.register_address <= fld_q[31:16];
							res_q.count_or_value <= fld_q[15:0];
							res_q.data_byte_count <= bc_q;
						end else begin
							res_q.frame_length <= '0;
							res_q.frame_start <= '0;
							res_q.slave_address <= '0;
							res_q.function_code <= '0;
							res_q.register_address <= '0;
							res_q.count_or_value <= '0;
							res_q.data_byte_count <= '0;
						end
						fill_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: dv/modbus_rtu_request_scanner_test.sv
`timescale 1ns / 100ps
// self-checking testbench for modbus_rtu_request_scanner: sends byte buffers holding
// framed requests, noise and broken frames, predicts every scan result and checks it
// depends on mrrs_pkg and rtl/modbus_rtu_request_scanner.sv
module modbus_rtu_request_scanner_test;
	import mrrs_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam logic [7:0] FC_READ_COILS    = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FC_READ_INPUT    = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FC_WRITE_REG     = 8'd6;
	localparam logic [7:0] FC_UNKNOWN       = 8'h2B;
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_ready;
	rx_t rx = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	// mirror of the scanner buffer
	logic [7:0] rx_bytes [BUFFER_DEPTH];
	int held_count = 0;
	logic dropped_any = 1'b0;
	res_t pending_results[$];

	int errors = 0;
	int bytes_sent = 0;
	int snd_gap_max = 4;
	int rcv_gap_max = 4;
	int hold_cycles = 0;

	modbus_rtu_request_scanner u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx(rx),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic is_multi_write(input logic [7:0] fc);
		return fc == FC_WRITE_COILS || fc == FC_WRITE_REGS;
	endfunction

	function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
		crc = crc ^ {8'h00, b};
		repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
		return crc;
	endfunction

	// first offset holding a crc-valid request
	function automatic res_t scan_for_request();
		res_t r;
		int need;
		logic [15:0] crc;
		r = '0;
		r.overflow = dropped_any;
		for (int i = 0; i + MIN_TAIL <= held_count; i++) begin
			if (is_multi_write(rx_bytes[i + 1])) begin
				if (held_count - i < MB_TAIL)
					continue;
				need = MB_LEN + rx_bytes[i + 6];
			end else begin
				need = BASE_LEN;
			end
			if (i + need > held_count)
				continue;
			crc = CRC_INIT;
			for (int k = 0; k < need - 2; k++)
				crc = crc_add_byte(crc, rx_bytes[i + k]);
			if ({rx_bytes[i + need - 1], rx_bytes[i + need - 2]} != crc)
				continue;
			r.found = 1'b1;
			r.frame_length = 9'(need);
			r.frame_start = 9'(i);
			r.slave_address = rx_bytes[i];
			r.function_code = rx_bytes[i + 1];
			r.register_address = {rx_bytes[i + 2], rx_bytes[i + 3]};
			r.count_or_value = {rx_bytes[i + 4], rx_bytes[i + 5]};
			if (is_multi_write(rx_bytes[i + 1]))
				r.data_byte_count = rx_bytes[i + 6];
			return r;
		end
		return r;
	endfunction

	task automatic absorb_byte(input logic [7:0] b, input logic last);
		if (held_count < BUFFER_DEPTH) begin
			rx_bytes[held_count] = b;
			held_count++;
		end else begin
			dropped_any = 1'b1;
		end
		if (last) begin
			pending_results.push_back(scan_for_request());
			held_count = 0;
			dropped_any = 1'b0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = $urandom_range(0, snd_gap_max);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx <= '{rx_byte: b, end_of_buffer: last};
		do @(posedge clk); while (!rx_ready);
		bytes_sent++;
		absorb_byte(b, last);
	endtask

	task automatic send_buffer(input byte_q_t q);
		foreach (q[k])
			send_byte(q[k], k == q.size() - 1);
	endtask

	task automatic settle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic byte_q_t build_request(input logic [7:0] slave, input logic [7:0] fc,
			input logic [15:0] addr, input logic [15:0] val, input logic [7:0] bc);
		byte_q_t q;
		logic [15:0] crc;
		q = '{slave, fc, addr[15:8], addr[7:0], val[15:8], val[7:0]};
		if (is_multi_write(fc)) begin
			q.push_back(bc);
			repeat (bc) q.push_back(8'($urandom_range(0, 255)));
		end
		crc = CRC_INIT;
		foreach (q[k])
			crc = crc_add_byte(crc, q[k]);
		q.push_back(crc[7:0]);
		q.push_back(crc[15:8]);
		return q;
	endfunction

	function automatic byte_q_t random_request();
		logic [7:0] fc;
		logic [7:0] bc;
		case ($urandom_range(0, 9))
			0: fc = FC_READ_COILS;
			1: fc = FC_READ_DISCRETE;
			2: fc = FC_READ_HOLDING;
			3: fc = FC_READ_INPUT;
			4: fc = FC_WRITE_COIL;
			5: fc = FC_WRITE_REG;
			6: fc = FC_WRITE_COILS;
			7: fc = FC_WRITE_REGS;
			default: fc = 8'($urandom_range(0, 255));
		endcase
		bc = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 60)) : 8'($urandom_range(0, 10));
		return build_request(8'($urandom_range(0, 255)), fc, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), bc);
	endfunction

	task automatic append(ref byte_q_t dst, input byte_q_t src);
		foreach (src[k])
			dst.push_back(src[k]);
	endtask

	task automatic push_noise(ref byte_q_t dst, input int n);
		repeat (n) dst.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic corrupt(ref byte_q_t q);
		int pos;
		pos = $urandom_range(0, q.size() - 1);
		q[pos] = q[pos] ^ 8'(1 << $urandom_range(0, 7));
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			$display("%0t unexpected result: expected none actual found=%0b start=%0d",
				$time, got.found, got.frame_start);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("found", 16'(want.found), 16'(got.found));
		compare_field("frame_length", 16'(want.frame_length), 16'(got.frame_length));
		compare_field("frame_start", 16'(want.frame_start), 16'(got.frame_start));
		compare_field("slave_address", 16'(want.slave_address), 16'(got.slave_address));
		compare_field("function_code", 16'(want.function_code), 16'(got.function_code));
		compare_field("register_address", want.register_address, got.register_address);
		compare_field("count_or_value", want.count_or_value, got.count_or_value);
		compare_field("data_byte_count", 16'(want.data_byte_count),
			16'(got.data_byte_count));
		compare_field("overflow", 16'(want.overflow), 16'(got.overflow));
	endtask

	// result side: per-result wait, plus long hold-offs on request
	initial begin
		int wait_left;
		wait_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				check_result(res);
				wait_left = $urandom_range(0, rcv_gap_max);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				res_ready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	task automatic test_short_buffers();
		byte_q_t q;
		send_buffer('{8'hA5});
		send_buffer('{8'h00, 8'hFF, 8'h00});
		// multi-write code with fewer than seven bytes left
		send_buffer('{8'h01, FC_WRITE_REGS, 8'h00, 8'h00, 8'h00, 8'h00});
		// request cut one byte short
		q = build_request(8'h01, FC_READ_HOLDING, 16'h0000, 16'h0001, 8'h00);
		void'(q.pop_back());
		send_buffer(q);
	endtask

	task automatic test_frame_kinds();
		byte_q_t q;
		send_buffer(build_request(8'h00, FC_READ_COILS, 16'h0000, 16'h0000, 8'h00));
		send_buffer(build_request(8'hFF, FC_READ_DISCRETE, 16'hFFFF, 16'hFFFF, 8'h00));
		send_buffer(build_request(8'h11, FC_READ_HOLDING, 16'h006B, 16'h0003, 8'h00));
		send_buffer(build_request(8'h12, FC_READ_INPUT, 16'h8000, 16'h7FFF, 8'h00));
		send_buffer(build_request(8'h13, FC_WRITE_COIL, 16'h00AC, 16'hFF00, 8'h00));
		send_buffer(build_request(8'h14, FC_WRITE_REG, 16'h0001, 16'h0003, 8'h00));
		send_buffer(build_request(8'h22, FC_WRITE_COILS, 16'h0013, 16'h000A, 8'h00));
		send_buffer(build_request(8'h23, FC_WRITE_REGS, 16'h0001, 16'h0002, 8'h04));
		send_buffer(build_request(8'h7E, FC_UNKNOWN, 16'h0E01, 16'h0000, 8'h00));
		q = build_request(8'h01, FC_READ_HOLDING, 16'h1234, 16'h0010, 8'h00);
		q[q.size() - 1] = q[q.size() - 1] ^ 8'h80;
		send_buffer(q);
	endtask

	task automatic test_scan_order();
		byte_q_t q;
		q = '{8'h55, 8'hAA, 8'h0F};
		append(q, build_request(8'h09, FC_READ_HOLDING, 16'h0100, 16'h0002, 8'h00));
		send_buffer(q);
		q = build_request(8'h01, FC_WRITE_REG, 16'h0002, 16'h0003, 8'h00);
		append(q, build_request(8'h02, FC_READ_COILS, 16'h0004, 16'h0005, 8'h00));
		send_buffer(q);
		q = build_request(8'h03, FC_READ_INPUT, 16'h0006, 16'h0007, 8'h00);
		corrupt(q);
		append(q, build_request(8'h04, FC_WRITE_REGS, 16'h0008, 16'h0001, 8'h02));
		send_buffer(q);
		// byte count that runs past the end of the buffer
		q = '{8'h05, FC_WRITE_REGS, 8'h00, 8'h01, 8'h00, 8'h02, 8'd200};
		append(q, build_request(8'h06, FC_READ_HOLDING, 16'h0000, 16'h0004, 8'h00));
		send_buffer(q);
	endtask

	task automatic test_long_frame();
		send_buffer(build_request(8'h7F, FC_WRITE_REGS, 16'hFFFF, 16'h007F, 8'hFF));
	endtask

	task automatic test_overflow();
		byte_q_t q;
		// request in the last places of a full buffer, then dropped bytes, the last one marked
		push_noise(q, BUFFER_DEPTH - BASE_LEN);
		append(q, build_request(8'h44, FC_READ_HOLDING, 16'hBEEF, 16'h0001, 8'h00));
		push_noise(q, 2);
		send_buffer(q);
		send_buffer(build_request(8'h46, FC_READ_COILS, 16'h0001, 16'h0001, 8'h00));
	endtask

	task automatic test_backpressure();
		snd_gap_max = 0;
		hold_cycles = 300;
		repeat (5) send_buffer(random_request());
		snd_gap_max = 4;
	endtask

	task automatic test_random();
		byte_q_t line_q;
		byte_q_t frame;
		int stop_at;
		int kind;
		stop_at = bytes_sent + 200;
		while (bytes_sent < stop_at) begin
			line_q = {};
			kind = $urandom_range(0, 9);
			snd_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			rcv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			if (kind == 8) begin
				push_noise(line_q, $urandom_range(1, 30));
			end else begin
				push_noise(line_q, $urandom_range(0, 5));
				frame = random_request();
				if (kind == 9) begin
					repeat ($urandom_range(1, 3)) void'(frame.pop_back());
				end else if ($urandom_range(0, 3) == 0) begin
					corrupt(frame);
				end
				append(line_q, frame);
				if (kind == 6 || kind == 7)
					append(line_q, random_request());
				push_noise(line_q, $urandom_range(0, 4));
			end
			send_buffer(line_q);
		end
		snd_gap_max = 4;
		rcv_gap_max = 4;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_buffers();
		settle();
		test_frame_kinds();
		settle();
		test_scan_order();
		settle();
		test_long_frame();
		settle();
		test_overflow();
		settle();
		test_backpressure();
		settle();
		test_random();
		settle();
		if (errors == 0) begin
			$display("PASS modbus_rtu_request_scanner");
		end else begin
			$display("FAIL modbus_rtu_request_scanner");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("FAIL modbus_rtu_request_scanner");
		$finish;
	end

endmodule

FILE: sim.f
rtl/mrrs_pkg.sv
rtl/modbus_rtu_request_scanner.sv
dv/modbus_rtu_request_scanner_test.sv
